>>> rtl/mtdk_pkg.sv
// ----------------------------------------------------------------------------
// mtdk_pkg
// Shared types, codes and constants of the motion-to-direction-key block.
// ----------------------------------------------------------------------------
package mtdk_pkg;

  localparam int unsigned SumWidthDef = 16;
  localparam int unsigned DeltaW      = 8;
  localparam int unsigned ExpW        = 8;
  localparam int unsigned SeenW       = 16;
  localparam int unsigned KeyW        = 3;
  localparam int unsigned LevelW      = 4;
  localparam int unsigned ThrW        = 7;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned LevelCount  = 9;

  localparam logic [LevelW-1:0] LevelReset = LevelW'(4);
  localparam logic [ExpW-1:0]   FloorReset = ExpW'(25);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSensitivity = 1'b0,
    CfgExposure    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OpMotion = 1'b0,
    OpIdle   = 1'b1
  } op_e;

  typedef enum logic [KeyW-1:0] {
    KeyNone  = 3'd0,
    KeyRight = 3'd1,
    KeyLeft  = 3'd2,
    KeyDown  = 3'd3,
    KeyUp    = 3'd4
  } key_e;

  function automatic logic [ThrW-1:0] thr_lookup(logic [LevelW-1:0] level);
    logic [ThrW-1:0] thr;
    case (level)
      4'd0:    thr = 7'd90;
      4'd1:    thr = 7'd80;
      4'd2:    thr = 7'd70;
      4'd3:    thr = 7'd60;
      4'd4:    thr = 7'd50;
      4'd5:    thr = 7'd45;
      4'd6:    thr = 7'd40;
      4'd7:    thr = 7'd35;
      4'd8:    thr = 7'd30;
      default: thr = 7'd50;
    endcase
    return thr;
  endfunction

endpackage

>>> rtl/mtdk_if.sv
// ----------------------------------------------------------------------------
// mtdk_in_if / mtdk_out_if
// Valid/ready channels for motion words and key result words.
// ----------------------------------------------------------------------------
interface mtdk_in_if
  import mtdk_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DeltaW-1:0] delta_x;
  logic signed [DeltaW-1:0] delta_y;
  logic        [ExpW-1:0]   max_exposure;

  modport source (output valid, opcode, delta_x, delta_y, max_exposure, input ready);
  modport sink   (input valid, opcode, delta_x, delta_y, max_exposure, output ready);
endinterface

interface mtdk_out_if
  import mtdk_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic        [KeyW-1:0]  key_code;
  logic signed [SeenW-1:0] sum_x_seen;
  logic signed [SeenW-1:0] sum_y_seen;

  modport source (output valid, key_code, sum_x_seen, sum_y_seen, input ready);
  modport sink   (input valid, key_code, sum_x_seen, sum_y_seen, output ready);
endinterface

>>> rtl/motion_to_direction_key.sv
// ----------------------------------------------------------------------------
// motion_to_direction_key
// Accumulates finger motion deltas and emits direction keys past a threshold.
// ----------------------------------------------------------------------------
// Path: input register holds the accepted word, result register its result.
// Throughput: 1 word per cycle; the add, saturate and compare sit in one stage.
// Output stalls pause it and back up through the input register to in_i.ready.
// Reset: async, active low; clears both sums and valid bits, sensitivity
// level to 4 and exposure floor to 25.
// ----------------------------------------------------------------------------
module motion_to_direction_key
  import mtdk_pkg::*;
#(
  parameter int unsigned SumWidth = SumWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  mtdk_in_if.sink             in_i,
  mtdk_out_if.source          out_o
);

  localparam int unsigned ExtW = (SumWidth > SeenW) ? SumWidth : SeenW;

  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

  logic                     s1_valid_q;
  logic                     s1_op_q;
  logic signed [DeltaW-1:0] s1_dx_q;
  logic signed [DeltaW-1:0] s1_dy_q;
  logic        [ExpW-1:0]   s1_exp_q;

  logic                     out_valid_q;
  logic        [KeyW-1:0]   key_q,    key_d;
  logic signed [SeenW-1:0]  seen_x_q, seen_x_d;
  logic signed [SeenW-1:0]  seen_y_q, seen_y_d;

  logic signed [SumWidth-1:0] sum_x_q, sum_x_d;
  logic signed [SumWidth-1:0] sum_y_q, sum_y_d;

  logic [LevelW-1:0] level_q;
  logic [ExpW-1:0]   floor_q;

  logic s2_load;
  logic s1_ready;

  logic signed [SumWidth:0]   raw_x, raw_y;
  logic signed [SumWidth-1:0] sat_x, sat_y;
  logic        [SumWidth-1:0] mag_x, mag_y, thr_ext;
  logic signed [ExtW-1:0]     ext_x, ext_y;
  key_e                       key;

  assign s2_load  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_ready = !s1_valid_q || s2_load;

  assign in_i.ready     = s1_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.key_code = key_q;
  assign out_o.sum_x_seen = seen_x_q;
  assign out_o.sum_y_seen = seen_y_q;

  // saturating accumulate
  assign raw_x = (SumWidth+1)'(sum_x_q) + (SumWidth+1)'(s1_dx_q);
  assign raw_y = (SumWidth+1)'(sum_y_q) + (SumWidth+1)'(s1_dy_q);

  always_comb begin
    if (raw_x[SumWidth] != raw_x[SumWidth-1]) begin
      sat_x = raw_x[SumWidth] ? SumMin : SumMax;
    end else begin
      sat_x = raw_x[SumWidth-1:0];
    end
    if (raw_y[SumWidth] != raw_y[SumWidth-1]) begin
      sat_y = raw_y[SumWidth] ? SumMin : SumMax;
    end else begin
      sat_y = raw_y[SumWidth-1:0];
    end
  end

  assign mag_x   = sat_x[SumWidth-1] ? (SumWidth)'(-sat_x) : sat_x;
  assign mag_y   = sat_y[SumWidth-1] ? (SumWidth)'(-sat_y) : sat_y;
  assign thr_ext = SumWidth'(thr_lookup(level_q));

  always_comb begin
    key = KeyNone;
    if (mag_x > mag_y && mag_x > thr_ext) begin
      key = (sat_x > 0) ? KeyRight : KeyLeft;
    end else if (mag_y > mag_x && mag_y > thr_ext) begin
      key = (sat_y > 0) ? KeyDown : KeyUp;
    end
  end

  always_comb begin
    key_d   = KeyNone;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    ext_x   = ExtW'(sum_x_q);
    ext_y   = ExtW'(sum_y_q);
    if (s1_op_q == OpIdle) begin
      sum_x_d = '0;
      sum_y_d = '0;
    end else if (s1_exp_q > floor_q) begin
      ext_x = ExtW'(sat_x);
      ext_y = ExtW'(sat_y);
      key_d = key;
      if (key != KeyNone) begin
        sum_x_d = '0;
        sum_y_d = '0;
      end else begin
        sum_x_d = sat_x;
        sum_y_d = sat_y;
      end
    end
    seen_x_d = ext_x[SeenW-1:0];
    seen_y_d = ext_y[SeenW-1:0];
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      level_q     <= LevelReset;
      floor_q     <= FloorReset;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_load) begin
        out_valid_q <= 1'b1;
        sum_x_q     <= sum_x_d;
        sum_y_q     <= sum_y_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgSensitivity: begin
            if (cfg_data_i[LevelW-1:0] < LevelW'(LevelCount)) begin
              level_q <= cfg_data_i[LevelW-1:0];
            end
          end
          CfgExposure: begin
            floor_q <= cfg_data_i[ExpW-1:0];
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_op_q  <= in_i.opcode;
      s1_dx_q  <= in_i.delta_x;
      s1_dy_q  <= in_i.delta_y;
      s1_exp_q <= in_i.max_exposure;
    end
    if (s2_load) begin
      key_q    <= key_d;
      seen_x_q <= seen_x_d;
      seen_y_q <= seen_y_d;
    end
  end

endmodule

>>> rtl/mtdk_checker.sv
// ----------------------------------------------------------------------------
// mtdk_checker
// Port-level checks of the motion-to-direction-key block, bound to the top.
// ----------------------------------------------------------------------------
module mtdk_checker
  import mtdk_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic        [KeyW-1:0]  key_code,
  input logic signed [SeenW-1:0] sum_x_seen,
  input logic signed [SeenW-1:0] sum_y_seen
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_key_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |->
      (key_code != KeyRight || sum_x_seen > 0) &&
      (key_code != KeyLeft  || sum_x_seen < 0) &&
      (key_code != KeyDown  || sum_y_seen > 0) &&
      (key_code != KeyUp    || sum_y_seen < 0))
    else $error("key direction disagrees with sum sign");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid)
    else $error("result valid out of reset");

endmodule

bind motion_to_direction_key mtdk_checker u_mtdk_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .key_code   (out_o.key_code),
  .sum_x_seen (out_o.sum_x_seen),
  .sum_y_seen (out_o.sum_y_seen)
);
